>>> src/fxalu_pkg.sv
package fxalu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    // The divider resolves every quotient bit of the shifted numerator so that
    // saturation is seen whatever the operands.
    localparam int QUOT_W    = NUM_W;
    // Radix-2 steps per divider pipeline stage.
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES = (QUOT_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
    localparam int EXP_UNIT  = 150 - FRAC_BITS;
    localparam int EXP_LIMIT = 158 - FRAC_BITS;

    localparam logic [DATA_W-1:0] SAT_MAG = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_DIV = 2'd1,
        OP_F2F = 2'd2,
        OP_ABS = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_DIV0 = 3'd1,
        ST_NAN  = 3'd2,
        ST_OVF  = 3'd3,
        ST_SAT  = 3'd4
    } t_status;

    function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [DATA_W-1:0] apply_sign(input logic [DATA_W-1:0] m,
                                                     input logic neg);
        return neg ? (~m + 1'b1) : m;
    endfunction

endpackage

>>> src/fxalu_div.sv
module fxalu_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [fxalu_pkg::DATA_W-1:0]  i_num,
    input  logic [fxalu_pkg::DATA_W-1:0]  i_den,
    output logic                          o_valid,
    output logic [fxalu_pkg::QUOT_W-1:0]  o_quot
);
    import fxalu_pkg::*;

    localparam int REM_W = DATA_W + 1;
    localparam int STEPS = DIV_STAGES * DIV_BITS_PER_STAGE;

    // Restoring division of (num << FRAC_BITS) by den, quotient bits generated
    // from bit STEPS-1 down; the numerator is shifted in one bit per step.
    logic [REM_W-1:0]  r_rem  [DIV_STAGES+1];
    logic [STEPS-1:0]  r_quot [DIV_STAGES+1];
    logic [STEPS-1:0]  r_nsh  [DIV_STAGES+1];
    logic [DATA_W-1:0] r_den  [DIV_STAGES+1];
    logic              r_vld  [DIV_STAGES+1];

    always_comb begin
        r_rem[0]  = '0;
        r_quot[0] = '0;
        r_nsh[0]  = STEPS'({i_num, {FRAC_BITS{1'b0}}});
        r_den[0]  = i_den;
        r_vld[0]  = i_valid;
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [REM_W-1:0] n_rem;
        logic [STEPS-1:0] n_quot;
        logic [STEPS-1:0] n_nsh;
        logic [REM_W-1:0] t;
        always_comb begin
            n_rem  = r_rem[s];
            n_quot = r_quot[s];
            n_nsh  = r_nsh[s];
            t      = '0;
            for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
                t      = {n_rem[REM_W-2:0], n_nsh[STEPS-1]};
                n_nsh  = {n_nsh[STEPS-2:0], 1'b0};
                if (t >= {1'b0, r_den[s]}) begin
                    n_rem  = t - {1'b0, r_den[s]};
                    n_quot = {n_quot[STEPS-2:0], 1'b1};
                end else begin
                    n_rem  = t;
                    n_quot = {n_quot[STEPS-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            r_rem[s+1]  <= n_rem;
            r_quot[s+1] <= n_quot;
            r_nsh[s+1]  <= n_nsh;
            r_den[s+1]  <= r_den[s];
        end
    end

    assign o_valid = r_vld[DIV_STAGES];
    // Numerator is below 2^48, so bits above QUOT_W are always zero.
    assign o_quot  = r_quot[DIV_STAGES][QUOT_W-1:0];

endmodule

>>> src/fixed_point_alu_16_16_unit.sv
// Q16.16 fixed-point ALU: multiply, divide, float-to-fixed and absolute value.
// Input channel: drive i_operation, i_operand_a and i_operand_b with start high;
// the operation transfers at a rising edge where start is high and busy is low.
// busy is tied low: one operation may be issued every cycle.
// Output channel: o_strobe is high for exactly one cycle with o_result and
// o_status; the result transfers at the edge that ends that cycle.
// Every operation takes the same path, its length set by the divider, which
// resolves four quotient bits per stage over twelve stages, plus an operand
// stage, a quotient alignment register and an output register. Multiply and
// the other operations travel in a delay line alongside it so results stay
// in order.
// Throughput is one result per cycle.
// A synchronous active-low reset clears every valid bit; nothing is in flight
// after reset. The receiver cannot stall, so no backpressure exists.
module fixed_point_alu_16_16_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_operation,
    input  logic signed [31:0]           i_operand_a,
    input  logic signed [31:0]           i_operand_b,
    output logic                         o_strobe,
    output logic signed [31:0]           o_result,
    output logic [2:0]                   o_status
);
    import fxalu_pkg::*;

    localparam int DLY = DIV_STAGES;

    // Stage 1: magnitudes, signs and operation decoding.
    logic              r1_vld;
    t_op               r1_op;
    logic [DATA_W-1:0] r1_ma, r1_mb, r1_a;
    logic              r1_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
        end
        r1_op  <= t_op'(i_operation);
        r1_a   <= i_operand_a;
        r1_ma  <= magnitude(i_operand_a);
        r1_mb  <= magnitude(i_operand_b);
        r1_neg <= i_operand_a[DATA_W-1] ^ i_operand_b[DATA_W-1];
    end

    // Stage 2: product and float conversion, computed for every item.
    logic [2*DATA_W-1:0] r2_prod;
    logic [DATA_W-1:0]   r2_f2f;
    t_status             r2_fst;

    logic [7:0]          f_ex;
    logic [23:0]         f_mant;
    logic [DATA_W-1:0]   f_v;
    logic [8:0]          f_sh;
    always_comb begin
        f_ex   = r1_a[30:23];
        f_mant = {1'b1, r1_a[22:0]};
        f_v    = '0;
        f_sh   = '0;
        if (f_ex <= 8'(EXP_UNIT)) begin
            f_sh = 9'(EXP_UNIT) - {1'b0, f_ex};
            f_v  = (f_sh >= 9'd32) ? '0 : (DATA_W'(f_mant) >> f_sh[4:0]);
        end else begin
            f_sh = {1'b0, f_ex} - 9'(EXP_UNIT);
            f_v  = DATA_W'(f_mant) << f_sh[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r2_prod <= {{DATA_W{1'b0}}, r1_ma} * {{DATA_W{1'b0}}, r1_mb};
        if (f_ex == 8'hff) begin
            r2_f2f <= '0;
            r2_fst <= ST_NAN;
        end else if (f_ex == 8'h00) begin
            r2_f2f <= '0;
            r2_fst <= ST_OK;
        end else if (f_ex > 8'(EXP_LIMIT)) begin
            r2_f2f <= '0;
            r2_fst <= ST_OVF;
        end else begin
            r2_f2f <= apply_sign(f_v, r1_a[DATA_W-1]);
            r2_fst <= ST_OK;
        end
    end

    // Divider runs in parallel from stage 1.
    logic              div_vld;
    logic [QUOT_W-1:0] div_q;

    fxalu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_vld),
        .i_num   (r1_ma),
        .i_den   (r1_mb),
        .o_valid (div_vld),
        .o_quot  (div_q)
    );

    // Delay line matching the divider latency, starting at stage 2 outputs.
    logic [DATA_W-1:0] r_d_other [DLY];
    t_status           r_d_st    [DLY];
    t_op               r_d_op    [DLY+1];
    logic              r_d_neg   [DLY+1];
    logic              r_d_zero  [DLY+1];
    logic [DATA_W-1:0] d_in_other;

    always_comb begin
        unique case (r1_op)
            OP_MUL:  d_in_other = '0;
            OP_DIV:  d_in_other = '0;
            OP_F2F:  d_in_other = '0;
            OP_ABS:  d_in_other = r1_ma;
            default: d_in_other = '0;
        endcase
    end

    logic [DATA_W-1:0] r2_abs;
    logic [DATA_W-1:0] n_other0;
    always_ff @(posedge i_clk) begin
        r2_abs      <= d_in_other;
        r_d_op[0]   <= r1_op;
        r_d_neg[0]  <= r1_neg;
        r_d_zero[0] <= (r1_mb == '0);
    end

    always_comb begin
        unique case (r_d_op[0])
            OP_MUL:  n_other0 = apply_sign(r2_prod[FRAC_BITS +: DATA_W], r_d_neg[0]);
            OP_F2F:  n_other0 = r2_f2f;
            OP_ABS:  n_other0 = r2_abs;
            default: n_other0 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_d_other[0] <= n_other0;
        r_d_st[0]    <= (r_d_op[0] == OP_F2F) ? r2_fst : ST_OK;
        for (int i = 1; i < DLY; i++) begin
            r_d_other[i] <= r_d_other[i-1];
            r_d_st[i]    <= r_d_st[i-1];
        end
        for (int i = 1; i <= DLY; i++) begin
            r_d_op[i]   <= r_d_op[i-1];
            r_d_neg[i]  <= r_d_neg[i-1];
            r_d_zero[i] <= r_d_zero[i-1];
        end
    end

    // One extra quotient register aligns the divider output with the delay line.
    logic [QUOT_W-1:0] r_q;
    logic              r_qv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= 1'b0;
        end else begin
            r_qv <= div_vld;
        end
        r_q <= div_q;
    end

    // Final stage.
    logic [DATA_W-1:0] n_res;
    t_status           n_st;
    always_comb begin
        n_res = r_d_other[DLY-1];
        n_st  = r_d_st[DLY-1];
        if (r_d_op[DLY] == OP_DIV) begin
            priority if (r_d_zero[DLY]) begin
                n_res = apply_sign(SAT_MAG, r_d_neg[DLY]);
                n_st  = ST_DIV0;
            end else if (r_q > QUOT_W'(SAT_MAG)) begin
                n_res = apply_sign(SAT_MAG, r_d_neg[DLY]);
                n_st  = ST_SAT;
            end else begin
                n_res = apply_sign(r_q[DATA_W-1:0], r_d_neg[DLY]);
                n_st  = ST_OK;
            end
        end
    end

    logic r_out_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_qv;
        end
        o_result <= n_res;
        o_status <= n_st;
    end

    assign busy     = 1'b0;
    assign o_strobe = r_out_vld;

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_status <= 3'd4))
        else $error("status code out of range");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_vld |-> ##(DIV_STAGES + 2) o_strobe)
        else $error("result strobe missing after fixed latency");

    a_f2f_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_NAN || o_status == ST_OVF)) |-> (o_result == '0))
        else $error("conversion error with nonzero result");

endmodule
